[rtl/mvna_pkg.sv]
// Package with the item types, command and status codes and sequencer states.
`timescale 1ns / 1ps
package mvna_pkg;

  localparam int POS_W  = 24;  // Q12.12 position
  localparam int SUM_W  = 28;  // accumulator width
  localparam int NRM_W  = 16;  // Q1.14 normal
  localparam int IDX_W  = 10;  // vertex index field
  localparam int DIF_W  = 25;  // position difference
  localparam int CRS_W  = 51;  // cross product component, signed
  localparam int MAG_W  = 51;  // magnitude before range reduction
  localparam int MUL_W  = 31;  // shared multiplier operand, signed
  localparam int PROD_W = 62;  // shared multiplier product
  localparam int ROOT_W = 64;  // square root working width
  localparam int LEN_W  = 32;  // vector length
  localparam int Q_W    = 15;  // quotient bits of one component
  localparam int NUM_W  = 45;  // dividend width

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_CORNER = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DEGEN   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    corner_last;
  } in_item_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [1:0]              status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RD_P0, S_RD_P1, S_RD_PL, S_DIFF, S_MUL,
    S_LOAD_SUM, S_ABS, S_SHIFT, S_SQ, S_SQRT, S_DIV_INIT, S_DIV,
    S_ACC_RD, S_ACC_SUM, S_ACC_WR, S_DONE
  } state_t;

endpackage

[rtl/mvna_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mesh_vertex_normal_averager_unit.sv]
// Top level of the vertex normal averager: sequencer, shared arithmetic and stores.
`timescale 1ns / 1ps
// The block keeps a table of vertex positions and a table of per-vertex normal
// sums. Items arrive on the in_ channel (valid/stall) and every item yields
// exactly one result item on the out_ channel. A write item stores a position.
// Corner items are collected in a small buffer; the final corner closes the
// polygon, which reads three positions, forms the cross product with six passes
// through one shared 31x31 multiplier, shifts the vector into range one bit per
// cycle, squares and sums it, takes an integer square root one result bit per
// cycle and divides each component by the length with a restoring divider. It
// then does a read-modify-write of the sums for each kept corner. A clear item
// zeroes the sum table one entry per cycle. The block takes one item at a time
// and holds in_stall high until it is done. After reset the same clearing pass
// runs before the first item is taken. A finished result waits in an output
// register, so the block takes the next item while a stalled result is still
// held; a second result waits inside the block until the output register is
// free.
module mesh_vertex_normal_averager_unit #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int MAX_CORNERS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mvna_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mvna_pkg::out_item_t out_data
);

  localparam int AW    = $clog2(VERTEX_DEPTH);
  localparam int CW    = $clog2(MAX_CORNERS);
  localparam int CNT_W = $clog2(MAX_CORNERS + 1);
  localparam int PW    = 3 * mvna_pkg::POS_W;
  localparam int SW    = 3 * mvna_pkg::SUM_W;

  // Control state.
  mvna_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             clr_reply_r, clr_reply_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Item and datapath registers.
  mvna_pkg::in_item_t  item_r, item_nxt;
  mvna_pkg::out_item_t out_r, out_nxt;
  logic [AW-1:0] c0_r, c0_nxt, c1_r, c1_nxt, cl_r, cl_nxt;
  logic signed [mvna_pkg::POS_W-1:0] p0_r [3];
  logic signed [mvna_pkg::POS_W-1:0] p0_nxt [3];
  logic signed [mvna_pkg::POS_W-1:0] p1_r [3];
  logic signed [mvna_pkg::POS_W-1:0] p1_nxt [3];
  logic signed [mvna_pkg::DIF_W-1:0] a_r [3];
  logic signed [mvna_pkg::DIF_W-1:0] a_nxt [3];
  logic signed [mvna_pkg::DIF_W-1:0] b_r [3];
  logic signed [mvna_pkg::DIF_W-1:0] b_nxt [3];
  logic signed [mvna_pkg::CRS_W-1:0] c_r [3];
  logic signed [mvna_pkg::CRS_W-1:0] c_nxt [3];
  logic [mvna_pkg::MAG_W-1:0] mag_r [3];
  logic [mvna_pkg::MAG_W-1:0] mag_nxt [3];
  logic [2:0] neg_r, neg_nxt;
  logic [3:0] step_r, step_nxt;
  logic signed [mvna_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [mvna_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [mvna_pkg::ROOT_W-1:0] sq_r, sq_nxt, sqr_r, sqr_nxt, sqb_r, sqb_nxt;
  logic [mvna_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [mvna_pkg::LEN_W:0] rem_r, rem_nxt;
  logic [mvna_pkg::Q_W-1:0] numlo_r, numlo_nxt, q_r, q_nxt;
  logic signed [mvna_pkg::NRM_W-1:0] nrm_r [3];
  logic signed [mvna_pkg::NRM_W-1:0] nrm_nxt [3];
  logic [1:0] status_r, status_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;

  // Corner buffer with a registered read port.
  logic [AW-1:0] cbuf [MAX_CORNERS];
  logic [AW-1:0] buf_q_r;
  logic          cbuf_we;

  // Position and sum tables.
  logic          pos_we;
  logic [AW-1:0] pos_raddr;
  logic [PW-1:0] pos_wdata, pos_rdata;
  logic          sum_we;
  logic [AW-1:0] sum_waddr, sum_raddr;
  logic [SW-1:0] sum_wdata, sum_rdata;

  // Decoded item and helper values.
  logic                 idx_ok, keep;
  logic [AW-1:0]        idx_addr;
  logic [CNT_W-1:0]     cnt_new;
  logic                 ovf_new;
  logic                 mag_zero, mag_big;
  logic [mvna_pkg::ROOT_W-1:0] sq_t, sqr_new;
  logic                 sq_ge;
  logic [mvna_pkg::NUM_W-1:0]  num;
  logic [mvna_pkg::LEN_W:0]    div_t;
  logic                 div_ge;
  logic [mvna_pkg::Q_W-1:0]    q_new;
  logic [2:0]           ps;

  assign idx_ok   = 32'(item_r.vertex_index) < 32'(VERTEX_DEPTH);
  assign idx_addr = AW'(item_r.vertex_index);
  assign keep     = idx_ok && (cnt_r < CNT_W'(MAX_CORNERS));
  assign cnt_new  = keep ? CNT_W'(cnt_r + 1'b1) : cnt_r;
  assign ovf_new  = ovf_r | ~keep;

  assign mag_zero = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
  assign mag_big  = (mag_r[0][mvna_pkg::MAG_W-1:30] != '0) ||
                    (mag_r[1][mvna_pkg::MAG_W-1:30] != '0) ||
                    (mag_r[2][mvna_pkg::MAG_W-1:30] != '0);

  // One bit of the integer square root.
  assign sq_t    = sqr_r + sqb_r;
  assign sq_ge   = sq_r >= sq_t;
  assign sqr_new = sq_ge ? ((sqr_r >> 1) + sqb_r) : (sqr_r >> 1);

  // One bit of the restoring division.
  assign num    = {1'b0, mag_r[comp_r][29:0], 14'd0} +
                  mvna_pkg::NUM_W'(len_r >> 1);
  assign div_t  = {rem_r[mvna_pkg::LEN_W-1:0], numlo_r[mvna_pkg::Q_W-1]};
  assign div_ge = div_t >= {1'b0, len_r};
  assign q_new  = {q_r[mvna_pkg::Q_W-2:0], div_ge};

  assign ps = 3'(step_r - 4'd1);

  function automatic logic signed [mvna_pkg::SUM_W-1:0] sat_add(
    input logic signed [mvna_pkg::SUM_W-1:0] s,
    input logic signed [mvna_pkg::NRM_W-1:0] n
  );
    logic signed [mvna_pkg::SUM_W:0] t;
    t = (mvna_pkg::SUM_W+1)'(s) + (mvna_pkg::SUM_W+1)'(n);
    if (t[mvna_pkg::SUM_W] != t[mvna_pkg::SUM_W-1]) begin
      sat_add = t[mvna_pkg::SUM_W] ? {1'b1, {(mvna_pkg::SUM_W-1){1'b0}}}
                                   : {1'b0, {(mvna_pkg::SUM_W-1){1'b1}}};
    end else begin
      sat_add = t[mvna_pkg::SUM_W-1:0];
    end
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mvna_pkg::S_CLEAR: begin
        if (clr_addr_r == AW'(VERTEX_DEPTH - 1)) begin
          state_nxt = clr_reply_r ? mvna_pkg::S_DONE : mvna_pkg::S_IDLE;
        end
      end
      mvna_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = mvna_pkg::S_DISPATCH;
        end
      end
      mvna_pkg::S_DISPATCH: begin
        case (item_r.cmd)
          mvna_pkg::CMD_CORNER: begin
            if (item_r.corner_last && cnt_new >= CNT_W'(3)) begin
              state_nxt = mvna_pkg::S_RD_P0;
            end else begin
              state_nxt = mvna_pkg::S_DONE;
            end
          end
          mvna_pkg::CMD_READ:  state_nxt = idx_ok ? mvna_pkg::S_LOAD_SUM : mvna_pkg::S_DONE;
          mvna_pkg::CMD_CLEAR: state_nxt = mvna_pkg::S_CLEAR;
          default:             state_nxt = mvna_pkg::S_DONE;
        endcase
      end
      mvna_pkg::S_RD_P0:    state_nxt = mvna_pkg::S_RD_P1;
      mvna_pkg::S_RD_P1:    state_nxt = mvna_pkg::S_RD_PL;
      mvna_pkg::S_RD_PL:    state_nxt = mvna_pkg::S_DIFF;
      mvna_pkg::S_DIFF:     state_nxt = mvna_pkg::S_MUL;
      mvna_pkg::S_MUL: begin
        if (step_r == 4'd6) begin
          state_nxt = mvna_pkg::S_ABS;
        end
      end
      mvna_pkg::S_LOAD_SUM: state_nxt = mvna_pkg::S_ABS;
      mvna_pkg::S_ABS:      state_nxt = mag_zero ? mvna_pkg::S_DONE : mvna_pkg::S_SHIFT;
      mvna_pkg::S_SHIFT: begin
        if (!mag_big) begin
          state_nxt = mvna_pkg::S_SQ;
        end
      end
      mvna_pkg::S_SQ: begin
        if (step_r == 4'd3) begin
          state_nxt = mvna_pkg::S_SQRT;
        end
      end
      mvna_pkg::S_SQRT: begin
        if (sqb_r[0]) begin
          state_nxt = mvna_pkg::S_DIV_INIT;
        end
      end
      mvna_pkg::S_DIV_INIT: state_nxt = mvna_pkg::S_DIV;
      mvna_pkg::S_DIV: begin
        if (step_r == 4'd14) begin
          if (comp_r != 2'd2) begin
            state_nxt = mvna_pkg::S_DIV_INIT;
          end else if (item_r.cmd == mvna_pkg::CMD_READ) begin
            state_nxt = mvna_pkg::S_DONE;
          end else begin
            state_nxt = mvna_pkg::S_ACC_RD;
          end
        end
      end
      mvna_pkg::S_ACC_RD:  state_nxt = mvna_pkg::S_ACC_SUM;
      mvna_pkg::S_ACC_SUM: state_nxt = mvna_pkg::S_ACC_WR;
      mvna_pkg::S_ACC_WR: begin
        state_nxt = (CNT_W'(k_r + 1'b1) == cnt_r) ? mvna_pkg::S_DONE : mvna_pkg::S_ACC_RD;
      end
      mvna_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = mvna_pkg::S_IDLE;
        end
      end
      default: state_nxt = mvna_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    cl_nxt        = cl_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    sq_nxt        = sq_r;
    sqr_nxt       = sqr_r;
    sqb_nxt       = sqb_r;
    len_nxt       = len_r;
    comp_nxt      = comp_r;
    rem_nxt       = rem_r;
    numlo_nxt     = numlo_r;
    q_nxt         = q_r;
    nrm_nxt       = nrm_r;
    status_nxt    = status_r;
    k_nxt         = k_r;
    mul_a         = '0;
    mul_b         = '0;
    cbuf_we       = 1'b0;
    pos_we        = 1'b0;
    pos_wdata     = {item_r.pos_x, item_r.pos_y, item_r.pos_z};
    pos_raddr     = c0_r;
    sum_we        = 1'b0;
    sum_waddr     = buf_q_r;
    sum_wdata     = '0;
    sum_raddr     = buf_q_r;

    case (state_r)
      mvna_pkg::S_CLEAR: begin
        sum_we       = 1'b1;
        sum_waddr    = clr_addr_r;
        clr_addr_nxt = AW'(clr_addr_r + 1'b1);
      end
      mvna_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      mvna_pkg::S_DISPATCH: begin
        status_nxt = mvna_pkg::ST_OK;
        comp_nxt   = 2'd0;
        step_nxt   = '0;
        k_nxt      = '0;
        sum_raddr  = idx_addr;
        case (item_r.cmd)
          mvna_pkg::CMD_WRITE: begin
            pos_we = idx_ok;
          end
          mvna_pkg::CMD_CORNER: begin
            cbuf_we = keep;
            if (keep) begin
              if (cnt_r == CNT_W'(0)) c0_nxt = idx_addr;
              if (cnt_r == CNT_W'(1)) c1_nxt = idx_addr;
              cl_nxt = idx_addr;
            end else begin
              status_nxt = mvna_pkg::ST_DROPPED;
            end
            cnt_nxt = cnt_new;
            ovf_nxt = ovf_new;
            if (item_r.corner_last) begin
              if (cnt_new < CNT_W'(3)) begin
                status_nxt = mvna_pkg::ST_DEGEN;
                cnt_nxt    = '0;
                ovf_nxt    = 1'b0;
              end else begin
                status_nxt = ovf_new ? mvna_pkg::ST_DROPPED : mvna_pkg::ST_OK;
              end
            end
          end
          mvna_pkg::CMD_READ: begin
            if (!idx_ok) begin
              status_nxt = mvna_pkg::ST_ZERO;
            end
          end
          default: begin
            clr_addr_nxt  = '0;
            clr_reply_nxt = 1'b1;
          end
        endcase
      end
      mvna_pkg::S_RD_P0: pos_raddr = c0_r;
      mvna_pkg::S_RD_P1: begin
        pos_raddr = c1_r;
        p0_nxt[0] = pos_rdata[PW-1 -: mvna_pkg::POS_W];
        p0_nxt[1] = pos_rdata[2*mvna_pkg::POS_W-1 -: mvna_pkg::POS_W];
        p0_nxt[2] = pos_rdata[mvna_pkg::POS_W-1:0];
      end
      mvna_pkg::S_RD_PL: begin
        pos_raddr = cl_r;
        p1_nxt[0] = pos_rdata[PW-1 -: mvna_pkg::POS_W];
        p1_nxt[1] = pos_rdata[2*mvna_pkg::POS_W-1 -: mvna_pkg::POS_W];
        p1_nxt[2] = pos_rdata[mvna_pkg::POS_W-1:0];
      end
      mvna_pkg::S_DIFF: begin
        a_nxt[0] = mvna_pkg::DIF_W'(p1_r[0]) - mvna_pkg::DIF_W'(p0_r[0]);
        a_nxt[1] = mvna_pkg::DIF_W'(p1_r[1]) - mvna_pkg::DIF_W'(p0_r[1]);
        a_nxt[2] = mvna_pkg::DIF_W'(p1_r[2]) - mvna_pkg::DIF_W'(p0_r[2]);
        b_nxt[0] = mvna_pkg::DIF_W'($signed(pos_rdata[PW-1 -: mvna_pkg::POS_W]))
                   - mvna_pkg::DIF_W'(p0_r[0]);
        b_nxt[1] = mvna_pkg::DIF_W'($signed(pos_rdata[2*mvna_pkg::POS_W-1 -:
                   mvna_pkg::POS_W])) - mvna_pkg::DIF_W'(p0_r[1]);
        b_nxt[2] = mvna_pkg::DIF_W'($signed(pos_rdata[mvna_pkg::POS_W-1:0]))
                   - mvna_pkg::DIF_W'(p0_r[2]);
        step_nxt = '0;
      end
      mvna_pkg::S_MUL: begin
        // Products in the order ay*bz, az*by, az*bx, ax*bz, ax*by, ay*bx.
        case (step_r)
          4'd0: begin mul_a = mvna_pkg::MUL_W'(a_r[1]); mul_b = mvna_pkg::MUL_W'(b_r[2]); end
          4'd1: begin mul_a = mvna_pkg::MUL_W'(a_r[2]); mul_b = mvna_pkg::MUL_W'(b_r[1]); end
          4'd2: begin mul_a = mvna_pkg::MUL_W'(a_r[2]); mul_b = mvna_pkg::MUL_W'(b_r[0]); end
          4'd3: begin mul_a = mvna_pkg::MUL_W'(a_r[0]); mul_b = mvna_pkg::MUL_W'(b_r[2]); end
          4'd4: begin mul_a = mvna_pkg::MUL_W'(a_r[0]); mul_b = mvna_pkg::MUL_W'(b_r[1]); end
          4'd5: begin mul_a = mvna_pkg::MUL_W'(a_r[1]); mul_b = mvna_pkg::MUL_W'(b_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        // The product of the previous step goes into its component.
        if (step_r != 4'd0) begin
          if (!ps[0]) begin
            c_nxt[ps[2:1]] = prod_r[mvna_pkg::CRS_W-1:0];
          end else begin
            c_nxt[ps[2:1]] = c_r[ps[2:1]] - prod_r[mvna_pkg::CRS_W-1:0];
          end
        end
        step_nxt = 4'(step_r + 1'b1);
      end
      mvna_pkg::S_LOAD_SUM: begin
        c_nxt[0] = mvna_pkg::CRS_W'($signed(sum_rdata[SW-1 -: mvna_pkg::SUM_W]));
        c_nxt[1] = mvna_pkg::CRS_W'($signed(sum_rdata[2*mvna_pkg::SUM_W-1 -:
                   mvna_pkg::SUM_W]));
        c_nxt[2] = mvna_pkg::CRS_W'($signed(sum_rdata[mvna_pkg::SUM_W-1:0]));
      end
      mvna_pkg::S_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_nxt[i] = c_r[i][mvna_pkg::CRS_W-1];
          mag_nxt[i] = c_r[i][mvna_pkg::CRS_W-1] ? mvna_pkg::MAG_W'(-c_r[i])
                                                 : mvna_pkg::MAG_W'(c_r[i]);
        end
        sq_nxt   = '0;
        step_nxt = '0;
        // A zero vector is recognized here from the signed components.
      end
      mvna_pkg::S_SHIFT: begin
        if (mag_big) begin
          for (int i = 0; i < 3; i++) begin
            mag_nxt[i] = mag_r[i] >> 1;
          end
        end
      end
      mvna_pkg::S_SQ: begin
        if (step_r != 4'd3) begin
          mul_a = {1'b0, mag_r[step_r[1:0]][29:0]};
          mul_b = {1'b0, mag_r[step_r[1:0]][29:0]};
        end
        if (step_r != 4'd0) begin
          sq_nxt = sq_r + mvna_pkg::ROOT_W'(unsigned'(prod_r));
        end
        sqr_nxt  = '0;
        sqb_nxt  = mvna_pkg::ROOT_W'(1) << 62;
        step_nxt = 4'(step_r + 1'b1);
      end
      mvna_pkg::S_SQRT: begin
        if (sq_ge) begin
          sq_nxt = sq_r - sq_t;
        end
        sqr_nxt  = sqr_new;
        sqb_nxt  = sqb_r >> 2;
        len_nxt  = sqr_new[mvna_pkg::LEN_W-1:0];
        comp_nxt = 2'd0;
      end
      mvna_pkg::S_DIV_INIT: begin
        rem_nxt   = (mvna_pkg::LEN_W+1)'(num[mvna_pkg::NUM_W-1:mvna_pkg::Q_W]);
        numlo_nxt = num[mvna_pkg::Q_W-1:0];
        q_nxt     = '0;
        step_nxt  = '0;
      end
      mvna_pkg::S_DIV: begin
        rem_nxt   = div_ge ? (div_t - {1'b0, len_r}) : div_t;
        numlo_nxt = numlo_r << 1;
        q_nxt     = q_new;
        step_nxt  = 4'(step_r + 1'b1);
        if (step_r == 4'd14) begin
          nrm_nxt[comp_r] = neg_r[comp_r] ? -mvna_pkg::NRM_W'(q_new)
                                          : mvna_pkg::NRM_W'(q_new);
          comp_nxt = 2'(comp_r + 1'b1);
        end
      end
      mvna_pkg::S_ACC_WR: begin
        sum_we    = 1'b1;
        sum_wdata = {sat_add(sum_rdata[SW-1 -: mvna_pkg::SUM_W], nrm_r[0]),
                     sat_add(sum_rdata[2*mvna_pkg::SUM_W-1 -: mvna_pkg::SUM_W], nrm_r[1]),
                     sat_add(sum_rdata[mvna_pkg::SUM_W-1:0], nrm_r[2])};
        k_nxt     = CNT_W'(k_r + 1'b1);
      end
      mvna_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.status = status_r;
          if (item_r.cmd == mvna_pkg::CMD_READ && status_r == mvna_pkg::ST_OK) begin
            out_nxt.normal_x = nrm_r[0];
            out_nxt.normal_y = nrm_r[1];
            out_nxt.normal_z = nrm_r[2];
          end else begin
            out_nxt.normal_x = '0;
            out_nxt.normal_y = '0;
            out_nxt.normal_z = '0;
          end
          clr_reply_nxt = 1'b0;
          // A closed polygon leaves an empty corner buffer behind.
          if (item_r.cmd == mvna_pkg::CMD_CORNER && item_r.corner_last) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end
      end
      default: begin
        cbuf_we = 1'b0;
      end
    endcase

    // A zero vector ends the item here.
    if (state_r == mvna_pkg::S_ABS && mag_zero) begin
      status_nxt = (item_r.cmd == mvna_pkg::CMD_READ) ? mvna_pkg::ST_ZERO
                                                       : mvna_pkg::ST_DEGEN;
    end

    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvna_pkg::S_CLEAR;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    c0_r     <= c0_nxt;
    c1_r     <= c1_nxt;
    cl_r     <= cl_nxt;
    p0_r     <= p0_nxt;
    p1_r     <= p1_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    step_r   <= step_nxt;
    prod_r   <= prod_nxt;
    sq_r     <= sq_nxt;
    sqr_r    <= sqr_nxt;
    sqb_r    <= sqb_nxt;
    len_r    <= len_nxt;
    comp_r   <= comp_nxt;
    rem_r    <= rem_nxt;
    numlo_r  <= numlo_nxt;
    q_r      <= q_nxt;
    nrm_r    <= nrm_nxt;
    status_r <= status_nxt;
    k_r      <= k_nxt;
  end

  // Corner buffer.
  always_ff @(posedge clk) begin
    if (cbuf_we) begin
      cbuf[cnt_r[CW-1:0]] <= idx_addr;
    end
    buf_q_r <= cbuf[k_r[CW-1:0]];
  end

  mvna_ram #(
    .WIDTH (PW),
    .DEPTH (VERTEX_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (idx_addr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  mvna_ram #(
    .WIDTH (SW),
    .DEPTH (VERTEX_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign in_stall  = (state_r != mvna_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[bench/mesh_vertex_normal_averager_unit_tb.sv]
// Testbench for the vertex normal averager: random and directed items, scoreboard check.
`timescale 1ns / 1ps
module mesh_vertex_normal_averager_unit_tb;

  localparam int DEPTH     = 1024;
  localparam int CORNERS   = 8;
  localparam int SUM_MAXV  = (1 << 27) - 1;
  localparam int SUM_MINV  = -(1 << 27);
  localparam longint LIMIT = 3000000;

  // Scoreboard: owns the model of the block's stores and the queue of
  // expected result items.
  class normal_board;
    logic signed [mvna_pkg::POS_W-1:0] px [DEPTH];
    logic signed [mvna_pkg::POS_W-1:0] py [DEPTH];
    logic signed [mvna_pkg::POS_W-1:0] pz [DEPTH];
    int sx [DEPTH];
    int sy [DEPTH];
    int sz [DEPTH];
    int unsigned held [CORNERS];
    int unsigned held_n;
    bit dropped;
    mvna_pkg::out_item_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        px[i] = '0; py[i] = '0; pz[i] = '0;
        sx[i] = 0; sy[i] = 0; sz[i] = 0;
      end
      held_n = 0;
      dropped = 0;
      errors = 0;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Unit vector in Q1.14; returns 0 for a vector with no direction.
    function automatic bit unit_q14(longint c0, longint c1, longint c2,
                                    output logic signed [mvna_pkg::NRM_W-1:0] o0,
                                    output logic signed [mvna_pkg::NRM_W-1:0] o1,
                                    output logic signed [mvna_pkg::NRM_W-1:0] o2);
      longint unsigned m [3];
      bit ng [3];
      longint c [3];
      longint unsigned mx, sq, len, q;
      logic signed [mvna_pkg::NRM_W-1:0] r [3];
      c[0] = c0; c[1] = c1; c[2] = c2;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        ng[i] = c[i] < 0;
        m[i] = ng[i] ? -c[i] : c[i];
        if (m[i] > mx) mx = m[i];
        r[i] = '0;
      end
      o0 = '0; o1 = '0; o2 = '0;
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += m[i] * m[i];
      len = root64(sq);
      if (len == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 16384 + len / 2) / len;
        r[i] = mvna_pkg::NRM_W'(ng[i] ? -q : q);
      end
      o0 = r[0]; o1 = r[1]; o2 = r[2];
      return 1;
    endfunction

    function automatic int sat(int a, int b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > SUM_MAXV) s = SUM_MAXV;
      if (s < SUM_MINV) s = SUM_MINV;
      return int'(s);
    endfunction

    function automatic logic [1:0] close_face();
      int unsigned i0, i1, il;
      longint ax, ay, az, bx, by, bz;
      logic signed [mvna_pkg::NRM_W-1:0] n0, n1, n2;
      if (held_n < 3) return mvna_pkg::ST_DEGEN;
      i0 = held[0]; i1 = held[1]; il = held[held_n-1];
      ax = longint'(px[i1]) - longint'(px[i0]);
      ay = longint'(py[i1]) - longint'(py[i0]);
      az = longint'(pz[i1]) - longint'(pz[i0]);
      bx = longint'(px[il]) - longint'(px[i0]);
      by = longint'(py[il]) - longint'(py[i0]);
      bz = longint'(pz[il]) - longint'(pz[i0]);
      if (!unit_q14(ay*bz - az*by, az*bx - ax*bz, ax*by - ay*bx, n0, n1, n2))
        return mvna_pkg::ST_DEGEN;
      for (int k = 0; k < held_n; k++) begin
        sx[held[k]] = sat(sx[held[k]], int'(n0));
        sy[held[k]] = sat(sy[held[k]], int'(n1));
        sz[held[k]] = sat(sz[held[k]], int'(n2));
      end
      return dropped ? mvna_pkg::ST_DROPPED : mvna_pkg::ST_OK;
    endfunction

    function void note_item(mvna_pkg::in_item_t it);
      mvna_pkg::out_item_t r;
      int unsigned idx;
      r = '0;
      r.status = mvna_pkg::ST_OK;
      idx = 32'(it.vertex_index);
      case (it.cmd)
        mvna_pkg::CMD_WRITE: begin
          px[idx] = it.pos_x; py[idx] = it.pos_y; pz[idx] = it.pos_z;
        end
        mvna_pkg::CMD_CORNER: begin
          if (held_n < CORNERS) begin
            held[held_n] = idx;
            held_n++;
          end else begin
            dropped = 1;
            r.status = mvna_pkg::ST_DROPPED;
          end
          if (it.corner_last) begin
            r.status = close_face();
            held_n = 0;
            dropped = 0;
          end
        end
        mvna_pkg::CMD_READ: begin
          if (!unit_q14(sx[idx], sy[idx], sz[idx], r.normal_x, r.normal_y, r.normal_z))
            r.status = mvna_pkg::ST_ZERO;
        end
        default: begin
          for (int i = 0; i < DEPTH; i++) begin
            sx[i] = 0; sy[i] = 0; sz[i] = 0;
          end
        end
      endcase
      pending = {pending, r};
    endfunction

    function void check_item(mvna_pkg::out_item_t got);
      mvna_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("result item with none expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.normal_x !== e.normal_x) begin
        $error("normal_x expected %0d actual %0d", e.normal_x, got.normal_x); errors++;
      end
      if (got.normal_y !== e.normal_y) begin
        $error("normal_y expected %0d actual %0d", e.normal_y, got.normal_y); errors++;
      end
      if (got.normal_z !== e.normal_z) begin
        $error("normal_z expected %0d actual %0d", e.normal_z, got.normal_z); errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  mvna_pkg::in_item_t in_data;
  mvna_pkg::out_item_t out_data;

  normal_board board;
  bit written [DEPTH];
  int unsigned known [$];   // indices with a position
  bit calm;                  // no idling in the final part
  bit hold_long;             // receiver holds off for a long stretch
  longint cycles;

  mesh_vertex_normal_averager_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Accept monitor and cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) board.note_item(in_data);
    if (rst_n && out_valid && !out_stall) board.check_item(out_data);
  end

  // Receiver: random stall bursts, plus one long hold-off.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_long = 0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until accepted; an idle burst may precede it.
  // Valid stays high after the accept so that a following item is offered
  // back to back; the caller drops it once the last item is taken.
  task automatic send_item(mvna_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_pos(int unsigned idx, logic [mvna_pkg::POS_W-1:0] x,
                         logic [mvna_pkg::POS_W-1:0] y, logic [mvna_pkg::POS_W-1:0] z);
    mvna_pkg::in_item_t it;
    it = '0;
    it.cmd = mvna_pkg::CMD_WRITE; it.vertex_index = mvna_pkg::IDX_W'(idx);
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.corner_last = 1'($urandom_range(0, 1));
    if (!written[idx]) known = {known, idx};
    written[idx] = 1;
    send_item(it);
  endtask

  task automatic put_cmd(logic [1:0] cmd, int unsigned idx, bit last);
    mvna_pkg::in_item_t it;
    it = '0;
    it.pos_x = mvna_pkg::POS_W'($urandom);
    it.pos_y = mvna_pkg::POS_W'($urandom);
    it.pos_z = mvna_pkg::POS_W'($urandom);
    it.cmd = cmd; it.vertex_index = mvna_pkg::IDX_W'(idx); it.corner_last = last;
    send_item(it);
  endtask

  // Index of a vertex that has a position (the polygon must stay in contract).
  function automatic int unsigned pick_known();
    return known[$urandom_range(0, known.size() - 1)];
  endfunction

  // Polygon with the given number of corners; corners beyond the buffer drop.
  task automatic put_polygon(int n);
    for (int k = 0; k < n; k++) put_cmd(mvna_pkg::CMD_CORNER, pick_known(), k == n - 1);
  endtask

  function automatic logic [mvna_pkg::POS_W-1:0] rnd_pos();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return mvna_pkg::POS_W'($urandom_range(0, 255) - 128);
      default: return mvna_pkg::POS_W'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    bit hold_armed;
    cycles = 0;
    calm = 0;
    hold_long = 0;
    hold_armed = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, a unit triangle, every command and special case.
    put_pos(0, 0, 0, 0);
    put_pos(1, 24'd4096, 0, 0);
    put_pos(2, 0, 24'd4096, 0);
    put_pos(1023, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    put_pos(3, 24'h800000, 24'h7FFFFF, 24'h800000);
    put_cmd(mvna_pkg::CMD_READ, 0, 0);                 // zero sum reads as zero
    put_polygon(3);
    put_cmd(mvna_pkg::CMD_CORNER, 0, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 1, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 2, 1);               // ok triangle
    put_cmd(mvna_pkg::CMD_READ, 0, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 0, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 1, 1);               // too few corners
    put_cmd(mvna_pkg::CMD_CORNER, 0, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 0, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 1, 1);               // zero area
    put_cmd(mvna_pkg::CMD_CORNER, 3, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 1023, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 0, 1);               // extreme coordinates
    put_polygon(11);                                    // buffer overflow
    put_cmd(mvna_pkg::CMD_READ, 1023, 0);
    put_cmd(mvna_pkg::CMD_CLEAR, 0, 0);
    put_cmd(mvna_pkg::CMD_READ, 1023, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 1, 0);
    put_cmd(mvna_pkg::CMD_CLEAR, 0, 0);                // clear keeps the open polygon
    put_cmd(mvna_pkg::CMD_CORNER, 2, 0);
    put_cmd(mvna_pkg::CMD_CORNER, 0, 1);

    // Random part: mostly writes, well-formed polygons and reads; some clears.
    sent = 0;
    while (sent < 1700) begin
      if (sent >= 300 && !hold_armed) begin
        hold_long = 1;
        hold_armed = 1;
      end
      if (sent >= 1450) calm = 1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          // Mostly a small set of indices so that sums build up.
          put_pos($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                            : $urandom_range(0, 15),
                  rnd_pos(), rnd_pos(), rnd_pos());
          sent++;
        end
        5, 6, 7, 8, 9, 10: begin
          int n;
          n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 11) : $urandom_range(3, 6);
          put_polygon(n);
          sent += n;
        end
        19: begin
          if ($urandom_range(0, 7) == 0) put_cmd(mvna_pkg::CMD_CLEAR, $urandom, 0);
          else put_cmd(mvna_pkg::CMD_READ, $urandom_range(0, 1023), 0);
          sent++;
        end
        default: begin
          put_cmd(mvna_pkg::CMD_READ, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                                : $urandom_range(0, 15), 0);
          sent++;
        end
      endcase
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Corner items use only known indices, so every index written at least once is
  // kept in the known list.
  initial begin
    for (int i = 0; i < DEPTH; i++) written[i] = 0;
  end

endmodule
